[hw/rtl/range_presence_detector_defines.svh]
// ----------------------------------------------------------------------------
// Range presence detector assertion macros
// Shared property shapes for the concurrent checks of the detector.
// ----------------------------------------------------------------------------
`ifndef RANGE_PRESENCE_DETECTOR_DEFINES_SVH
`define RANGE_PRESENCE_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("range presence detector: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("range presence detector: next-cycle check failed");

`endif

[hw/rtl/rpd_pkg.sv]
// ----------------------------------------------------------------------------
// Range presence detector package
// Field widths, register indexes, event codes and the configuration struct.
// ----------------------------------------------------------------------------
package rpd_pkg;

	// Field widths.
	localparam int RANGE_W     = 16;
	localparam int EVENT_W     = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_BOGUS_LIMIT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD = 1'd1;

	// Register reset values.
	localparam logic [CFG_DATA_W-1:0] BOGUS_LIMIT_RST    = 16'd25;
	localparam logic [CFG_DATA_W-1:0] DROP_THRESHOLD_RST = 16'd25;

	// Reported events.
	typedef enum logic [EVENT_W-1:0] {
		EV_NONE = 2'd0,
		EV_BUSY = 2'd1,
		EV_FREE = 2'd2
	} event_t;

	// Live configuration handed to the detector.
	typedef struct packed {
		logic [CFG_DATA_W-1:0] bogus_limit;
		logic [CFG_DATA_W-1:0] drop_threshold;
	} cfg_t;

endpackage

[hw/rtl/rpd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Range presence detector configuration registers
// Holds the bogus limit and the drop threshold written over the config port.
// ----------------------------------------------------------------------------
module rpd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [rpd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rpd_pkg::CFG_DATA_W-1:0] wr_data,
	output rpd_pkg::cfg_t                  cfg
);
	import rpd_pkg::*;

	logic [CFG_DATA_W-1:0] bogus_limit_q;
	logic [CFG_DATA_W-1:0] drop_threshold_q;

	// Register file, one beat writes one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bogus_limit_q    <= BOGUS_LIMIT_RST;
			drop_threshold_q <= DROP_THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BOGUS_LIMIT:    bogus_limit_q    <= wr_data;
				REG_DROP_THRESHOLD: drop_threshold_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg.bogus_limit    = bogus_limit_q;
	assign cfg.drop_threshold = drop_threshold_q;

endmodule

[hw/rtl/rpd_mean.sv]
// ----------------------------------------------------------------------------
// Range presence detector mean unit
// Divides the calibration sum by the sample count with a reciprocal multiply.
// ----------------------------------------------------------------------------
module rpd_mean #(
	parameter int CALIB_SAMPLES = 30,
	parameter int SUM_W         = 21
) (
	input  logic [SUM_W-1:0]            sum,
	output logic [rpd_pkg::RANGE_W-1:0] mean
);
	import rpd_pkg::*;

	// With the shift set to the sum width plus ceil(log2 N), the rounded-up
	// reciprocal gives the exact floor quotient for every sum value.
	localparam int DIV_SHIFT = SUM_W + $clog2(CALIB_SAMPLES);
	localparam int MULT_W    = DIV_SHIFT + 1;
	localparam int PROD_W    = SUM_W + MULT_W;
	localparam longint unsigned DIV_MULT =
		((64'd1 << DIV_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;

	logic [MULT_W-1:0] recip;
	logic [PROD_W-1:0] prod;

	assign recip = MULT_W'(DIV_MULT);

	// Single multiply, the quotient is a slice of the product.
	always_comb begin
		prod = PROD_W'(sum) * PROD_W'(recip);
		mean = prod[DIV_SHIFT +: RANGE_W];
	end

endmodule

[hw/rtl/rpd_detect.sv]
// ----------------------------------------------------------------------------
// Range presence detector decision logic
// Calibration accumulator, baseline and occupancy state with event decode.
// ----------------------------------------------------------------------------
`include "range_presence_detector_defines.svh"

module rpd_detect #(
	parameter int CALIB_SAMPLES = 30
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [rpd_pkg::RANGE_W-1:0]  range_val,
	input  rpd_pkg::cfg_t                cfg,
	output rpd_pkg::event_t              event_nxt,
	output logic                         calib_nxt
);
	import rpd_pkg::*;

	localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
	localparam int SUM_W = RANGE_W + CNT_W;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CALIB_SAMPLES - 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   sum_q;
	logic [RANGE_W-1:0] base_q;
	logic               calib_q;
	logic [1:0]         below_q;

	logic [SUM_W-1:0]   sum_nxt;
	logic [RANGE_W-1:0] mean;
	logic               calib_done;
	logic [RANGE_W:0]   limit_diff;
	logic               occupied;
	logic               valid_read;
	logic [1:0]         below_nxt;

	// Running sum including the current reading, and its mean.
	assign sum_nxt    = sum_q + SUM_W'(range_val);
	assign calib_done = !calib_q && (cnt_q == CNT_LAST);

	rpd_mean #(
		.CALIB_SAMPLES (CALIB_SAMPLES),
		.SUM_W         (SUM_W)
	) u_mean (
		.sum  (sum_nxt),
		.mean (mean)
	);

	// A baseline below the threshold wraps, so every valid reading is occupied.
	assign limit_diff = {1'b0, base_q} - {1'b0, cfg.drop_threshold};
	assign occupied   = limit_diff[RANGE_W] || (range_val < limit_diff[RANGE_W-1:0]);
	assign valid_read = calib_q && (range_val >= cfg.bogus_limit);

	// Occupancy counter update and event decode.
	always_comb begin
		below_nxt = below_q;
		event_nxt = EV_NONE;
		if (valid_read) begin
			if (occupied) begin
				if (below_q != 2'd2) begin
					below_nxt = below_q + 2'd1;
				end
				if (below_nxt == 2'd1) begin
					event_nxt = EV_BUSY;
				end
			end else if (below_q != 2'd0) begin
				event_nxt = EV_FREE;
				below_nxt = 2'd0;
			end
		end
	end

	assign calib_nxt = calib_q || calib_done;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			calib_q <= 1'b0;
			below_q <= 2'd0;
		end else if (step) begin
			if (!calib_q) begin
				cnt_q   <= cnt_q + CNT_W'(1);
				sum_q   <= sum_nxt;
				calib_q <= calib_done;
			end
			below_q <= below_nxt;
		end
	end

	// Baseline is loaded once when calibration completes.
	always_ff @(posedge clk) begin
		if (step && calib_done) begin
			base_q <= mean;
		end
	end

	`RPD_ASSERT_NEXT(a_calib_sticky, clk, arst_n, calib_q, calib_q)
	`RPD_ASSERT_SAME(a_below_needs_calib, clk, arst_n, below_q != 2'd0, calib_q)
	`RPD_ASSERT_SAME(a_cnt_in_range, clk, arst_n, !calib_q, cnt_q <= CNT_LAST)
	`RPD_ASSERT_NEXT(a_busy_first, clk, arst_n, step && (event_nxt == EV_BUSY),
		below_q == 2'd1)
	`RPD_ASSERT_NEXT(a_free_clears, clk, arst_n, step && (event_nxt == EV_FREE),
		below_q == 2'd0)

endmodule

[hw/rtl/range_presence_detector.sv]
// ----------------------------------------------------------------------------
// Range presence detector
// Calibrates a baseline from the first readings, then reports BUSY and FREE
// events as readings fall below baseline minus drop threshold and recover.
// ----------------------------------------------------------------------------
//  channel | signals                              | beat moves when
//  --------+--------------------------------------+---------------------------
//  input   | in_valid, in_stall, range_cm         | in_valid && !in_stall
//  output  | out_valid, out_stall, event_code,    | out_valid && !out_stall
//          | calibrated                           |
//  config  | cfg_valid, cfg_ready, cfg_index,     | cfg_valid && cfg_ready
//          | cfg_data                             |
//
// One beat per cycle sustained while out_stall is low; an accepted beat is
// held in the input register, then in the result register, where it leaves.
// The decision for a beat is two compares and a counter update, plus one
// reciprocal multiply on the beat that completes calibration.
// Reset clears calibration and occupancy, not the baseline; no clearing pass.
// in_stall rises only while both registers are full and the output is stalled.
// cfg_ready is always high; a new value applies from the next beat.
// ----------------------------------------------------------------------------
module range_presence_detector #(
	parameter int CALIB_SAMPLES = 30
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rpd_pkg::RANGE_W-1:0]    range_cm,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rpd_pkg::EVENT_W-1:0]    event_code,
	output logic                           calibrated,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rpd_pkg::*;

	cfg_t               cfg;
	logic               valid_s1;
	logic [RANGE_W-1:0] range_s1;
	logic               valid_s2;
	event_t             event_s2;
	logic               calib_s2;
	logic               s2_free;
	logic               advance;
	logic               in_take;
	event_t             event_nxt;
	logic               calib_nxt;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	rpd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Pipeline flow control.
	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || advance) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			range_s1 <= range_cm;
		end
	end

	// Decision logic and state.
	rpd_detect #(
		.CALIB_SAMPLES (CALIB_SAMPLES)
	) u_detect (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.range_val (range_s1),
		.cfg       (cfg),
		.event_nxt (event_nxt),
		.calib_nxt (calib_nxt)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2 <= event_nxt;
			calib_s2 <= calib_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign event_code = event_s2;
	assign calibrated = calib_s2;

endmodule
